// ===== sv/adst_pkg.sv =====
// adst_pkg: shared types, constants and register codes of the
// advection-diffusion stencil block; no dependencies

package adst_pkg;

   // default grid line length of the row stores
   localparam int GRID_WIDTH_DEFAULT = 1024;

   // payload field widths
   localparam int CONC_W   = 32;   // signed Q16.16 cell value
   localparam int OUT_W    = 31;   // non-negative Q16.16 result
   localparam int STATUS_W = 2;
   localparam int COEF_W   = 32;   // signed Q4.28 coefficient
   localparam int COLS_W   = 11;   // columns_in_use register
   localparam int CSR_IDX_W = 3;

   // reset value of the column register
   localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(1024);

   // result buffer depth, covers every result in flight in the pipeline
   localparam int RSP_FIFO_DEPTH = 8;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DIFF_X  = 3'd0,
      REG_DIFF_Y  = 3'd1,
      REG_ADV_X   = 3'd2,
      REG_ADV_Y   = 3'd3,
      REG_LOSS    = 3'd4,
      REG_COLUMNS = 3'd5
   } reg_index_type;

   // clamp status codes
   typedef enum logic [STATUS_W-1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_NEG  = 2'd1,
      CLAMP_OVF  = 2'd2
   } clamp_type;

endpackage

// ===== sv/adst_if.sv =====
// adst channel interfaces: input cell beats, result beats and
// configuration writes; depends on adst_pkg

// input cell channel
interface adst_req_if import adst_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic signed [CONC_W-1:0] conc_in;

   modport source (output valid, output mode, output conc_in, input ready);
   modport sink   (input valid, input mode, input conc_in, output ready);
endinterface

// result channel
interface adst_rsp_if import adst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OUT_W-1:0]    conc_next;
   logic [STATUS_W-1:0] clamp_status;
   logic                end_of_row;
   logic                end_of_frame;

   modport source (output valid, output conc_next, output clamp_status,
                   output end_of_row, output end_of_frame, input ready);
   modport sink   (input valid, input conc_next, input clamp_status,
                   input end_of_row, input end_of_frame, output ready);
endinterface

// configuration write channel
interface adst_csr_if import adst_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COEF_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/advection_diffusion_stencil_top.sv =====
// advection_diffusion_stencil_top: one explicit time step of a 2D
// advection-diffusion-decay stencil over a raster stream of cells
// depends on adst_pkg and the channel interfaces in adst_if.sv
//
// usage
//  - req_chan carries one cell per beat in raster order (mode 0), then one
//    row of padding beats (mode 1) after the last grid row to flush it
//  - rsp_chan returns one result per beat for the row above the incoming
//    one; the first grid row produces no results, it only fills the stores
//  - csr_chan writes the five Q4.28 coefficients and columns_in_use; it is
//    always ready; the user must write it only while the block is idle, unchecked by the block
//  - a result is registered through the pipeline stages into the result buffer after the
//    cell beat that completes its stencil; throughput is one beat per cycle while ready is high,
//    set by the single read-modify-write pass over the two row memories per beat
//  - the receiver may stall: an 8-entry result buffer absorbs the pipeline
//    and req_chan.ready drops when it lacks room for all in flight, or on a refetch
//  - a write of columns_in_use triggers a re-read of the center row
//    memory, during which no cell beat is taken
//  - reset clears coefficients and control and sets the column count to 1024;
//    the row memories are not cleared, the first row is always written before it is read

module advection_diffusion_stencil_top
   import adst_pkg::*;
#(
   parameter int GRID_WIDTH = GRID_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   adst_req_if.sink   req_chan,
   adst_rsp_if.source rsp_chan,
   adst_csr_if.sink   csr_chan
);

   // derived widths
   localparam int COL_W     = $clog2(GRID_WIDTH);
   localparam int CNT_W     = $clog2(GRID_WIDTH + 1);
   localparam int CMP_W     = (CNT_W > COLS_W) ? CNT_W : COLS_W;
   localparam int TERM_W    = CONC_W + 3;
   localparam int MUL_W     = COEF_W + TERM_W;
   localparam int PROD_W    = MUL_W - 11;
   localparam int SUM_W     = PROD_W + 4;
   localparam int RES_W     = SUM_W - 16;
   localparam int PTR_W     = $clog2(RSP_FIFO_DEPTH);
   localparam int FCNT_W    = $clog2(RSP_FIFO_DEPTH + 1);
   localparam int OCC_W     = FCNT_W + 1;

   typedef struct packed {
      logic [OUT_W-1:0]    conc_next;
      logic [STATUS_W-1:0] clamp_status;
      logic                end_of_row;
      logic                end_of_frame;
   } rsp_entry_type;

   // configuration registers
   logic signed [COEF_W-1:0] coef_dx_ff, coef_dy_ff, coef_ax_ff, coef_ay_ff, coef_loss_ff;
   logic [COLS_W-1:0]        cols_ff;
   logic                     refetch_ff;

   // stream control state
   logic [COL_W-1:0]         col_count_ff, col_count_in;
   logic                     emit_ff, emit_in;
   logic                     first_row_ff, first_row_in;
   logic signed [CONC_W-1:0] window_left_ff;

   // row memories
   logic [CONC_W-1:0]        center_mem [GRID_WIDTH];
   logic [CONC_W-1:0]        upper_mem  [GRID_WIDTH];
   logic [CONC_W-1:0]        ctr_rd_ff, upr_rd_ff, fwd_data_ff;
   logic                     fwd_hit_ff;
   logic                     ctr_we, ctr_re, upr_we, upr_re;
   logic [COL_W-1:0]         ctr_wa, ctr_ra;
   logic [CONC_W-1:0]        ctr_wd;
   logic signed [CONC_W-1:0] center_data;

   // column decode
   logic [CMP_W-1:0]         w_eff, j_ext, j_cl, j_inc;
   logic [COL_W-1:0]         j_col, next_col;
   logic                     row_last;
   logic                     req_fire, pad;
   logic signed [CONC_W-1:0] in_bits;
   logic                     s1_load;

   // pipeline stages
   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [CONC_W-1:0] s1_c_ff, s1_l_ff, s1_d_ff;
   logic                     s1_first_ff, s1_last_ff, s1_eof_ff;
   logic signed [CONC_W-1:0] s2_r, s2_u;
   logic signed [TERM_W-1:0] s2_tdx_ff, s2_tdy_ff, s2_tax_ff, s2_tay_ff;
   logic signed [CONC_W-1:0] s2_c_ff;
   logic                     s2_last_ff, s2_eof_ff;
   logic signed [MUL_W-1:0]  m_dx, m_dy, m_ax, m_ay, m_loss;
   logic signed [PROD_W-1:0] s3_pdx_ff, s3_pdy_ff, s3_pax_ff, s3_pay_ff, s3_ploss_ff;
   logic signed [CONC_W-1:0] s3_c_ff;
   logic                     s3_last_ff, s3_eof_ff;
   logic signed [SUM_W-1:0]  s4_gain_ff, s4_drop_ff;
   logic                     s4_last_ff, s4_eof_ff;
   logic signed [SUM_W-1:0]  sum_total;
   logic signed [RES_W-1:0]  res;
   rsp_entry_type            push_entry;

   // result buffer
   rsp_entry_type            fifo_mem [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [FCNT_W-1:0]        fifo_count_ff;
   logic                     rsp_pop;
   logic [OCC_W-1:0]         occupancy;

   // configuration writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_dx_ff   <= '0;
         coef_dy_ff   <= '0;
         coef_ax_ff   <= '0;
         coef_ay_ff   <= '0;
         coef_loss_ff <= '0;
         cols_ff      <= COLS_RESET;
         refetch_ff   <= 1'b0;
      end else begin
         refetch_ff <= 1'b0;
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               REG_DIFF_X:  coef_dx_ff   <= csr_chan.data;
               REG_DIFF_Y:  coef_dy_ff   <= csr_chan.data;
               REG_ADV_X:   coef_ax_ff   <= csr_chan.data;
               REG_ADV_Y:   coef_ay_ff   <= csr_chan.data;
               REG_LOSS:    coef_loss_ff <= csr_chan.data;
               REG_COLUMNS: begin
                  cols_ff    <= csr_chan.data[COLS_W-1:0];
                  refetch_ff <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // effective row length and clamped column
   always_comb begin
      w_eff = CMP_W'(cols_ff);
      if (w_eff == '0) begin
         w_eff = CMP_W'(1);
      end else if (w_eff > CMP_W'(GRID_WIDTH)) begin
         w_eff = CMP_W'(GRID_WIDTH);
      end
      j_ext = CMP_W'(col_count_ff);
      j_cl  = (j_ext >= w_eff) ? (w_eff - CMP_W'(1)) : j_ext;
      j_inc = j_cl + CMP_W'(1);
      row_last = (j_inc >= w_eff);
      j_col    = j_cl[COL_W-1:0];
      next_col = row_last ? '0 : j_inc[COL_W-1:0];
   end

   // input handshake: no refetch and room in the buffer for everything in flight
   assign occupancy = OCC_W'(fifo_count_ff) + OCC_W'(v1_ff) + OCC_W'(v2_ff)
                    + OCC_W'(v3_ff) + OCC_W'(v4_ff);
   assign req_chan.ready = !refetch_ff && (occupancy < OCC_W'(RSP_FIFO_DEPTH));
   assign req_fire = req_chan.valid && req_chan.ready;
   assign pad      = req_chan.mode;
   assign in_bits  = pad ? '0 : req_chan.conc_in;

   // center cell, forwarded when the previous read hit the entry being written
   assign center_data = fwd_hit_ff ? fwd_data_ff : ctr_rd_ff;

   // memory access and state update for one beat
   always_comb begin
      ctr_we       = 1'b0;
      ctr_re       = 1'b0;
      ctr_wa       = j_col;
      ctr_wd       = in_bits;
      ctr_ra       = next_col;
      upr_we       = 1'b0;
      upr_re       = 1'b0;
      s1_load      = 1'b0;
      emit_in      = emit_ff;
      first_row_in = first_row_ff;
      col_count_in = col_count_ff;
      priority if (refetch_ff) begin
         // column count changed: reload the prefetched center cell
         ctr_re = 1'b1;
         ctr_ra = j_col;
      end else if (req_fire && !emit_ff) begin
         // loading the first row, padding is dropped
         if (!pad) begin
            ctr_we       = 1'b1;
            ctr_re       = 1'b1;
            col_count_in = next_col;
            if (row_last) begin
               emit_in = 1'b1;
            end
         end
      end else if (req_fire) begin
         ctr_we       = 1'b1;
         ctr_re       = 1'b1;
         upr_we       = 1'b1;
         upr_re       = 1'b1;
         s1_load      = 1'b1;
         col_count_in = next_col;
         if (row_last && pad) begin
            emit_in      = 1'b0;
            first_row_in = 1'b1;
         end else if (row_last) begin
            first_row_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff        <= 1'b0;
         first_row_ff   <= 1'b1;
         col_count_ff   <= '0;
         window_left_ff <= '0;
      end else begin
         emit_ff      <= emit_in;
         first_row_ff <= first_row_in;
         col_count_ff <= col_count_in;
         if (s1_load) begin
            window_left_ff <= center_data;
         end
      end
   end

   // center row memory: prefetches the next column's cell
   always_ff @(posedge clock) begin
      if (ctr_we) begin
         center_mem[ctr_wa] <= ctr_wd;
      end
      if (ctr_re) begin
         ctr_rd_ff   <= center_mem[ctr_ra];
         fwd_hit_ff  <= ctr_we && (ctr_wa == ctr_ra);
         fwd_data_ff <= ctr_wd;
      end
   end

   // upper row memory: read old value, write the retiring center cell
   always_ff @(posedge clock) begin
      if (upr_we) begin
         upper_mem[j_col] <= center_data;
      end
      if (upr_re) begin
         upr_rd_ff <= upper_mem[j_col];
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= s1_load;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage 1: cells known at the beat
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_c_ff     <= center_data;
         s1_l_ff     <= (j_col != '0) ? window_left_ff : '0;
         s1_d_ff     <= in_bits;
         s1_first_ff <= first_row_ff;
         s1_last_ff  <= row_last;
         s1_eof_ff   <= row_last && pad;
      end
   end

   // stage 2: right and upper neighbors arrive, form stencil differences
   assign s2_r = s1_last_ff  ? '0 : center_data;
   assign s2_u = s1_first_ff ? '0 : $signed(upr_rd_ff);

   always_ff @(posedge clock) begin
      s2_tdx_ff <= TERM_W'(s2_r) - (TERM_W'(s1_c_ff) <<< 1) + TERM_W'(s1_l_ff);
      s2_tdy_ff <= TERM_W'(s1_d_ff) - (TERM_W'(s1_c_ff) <<< 1) + TERM_W'(s2_u);
      s2_tax_ff <= coef_ax_ff[COEF_W-1] ? (TERM_W'(s2_r) - TERM_W'(s1_c_ff))
                                        : (TERM_W'(s1_c_ff) - TERM_W'(s1_l_ff));
      s2_tay_ff <= coef_ay_ff[COEF_W-1] ? (TERM_W'(s1_d_ff) - TERM_W'(s1_c_ff))
                                        : (TERM_W'(s1_c_ff) - TERM_W'(s2_u));
      s2_c_ff    <= s1_c_ff;
      s2_last_ff <= s1_last_ff;
      s2_eof_ff  <= s1_eof_ff;
   end

   // stage 3: five coefficient products, floored to 2^-32
   assign m_dx   = coef_dx_ff   * s2_tdx_ff;
   assign m_dy   = coef_dy_ff   * s2_tdy_ff;
   assign m_ax   = coef_ax_ff   * s2_tax_ff;
   assign m_ay   = coef_ay_ff   * s2_tay_ff;
   assign m_loss = coef_loss_ff * TERM_W'(s2_c_ff);

   always_ff @(posedge clock) begin
      s3_pdx_ff   <= PROD_W'(m_dx   >>> 12);
      s3_pdy_ff   <= PROD_W'(m_dy   >>> 12);
      s3_pax_ff   <= PROD_W'(m_ax   >>> 12);
      s3_pay_ff   <= PROD_W'(m_ay   >>> 12);
      s3_ploss_ff <= PROD_W'(m_loss >>> 12);
      s3_c_ff     <= s2_c_ff;
      s3_last_ff  <= s2_last_ff;
      s3_eof_ff   <= s2_eof_ff;
   end

   // stage 4: gains and losses summed separately
   always_ff @(posedge clock) begin
      s4_gain_ff <= (SUM_W'(s3_c_ff) <<< 16) + SUM_W'(s3_pdx_ff) + SUM_W'(s3_pdy_ff);
      s4_drop_ff <= SUM_W'(s3_pax_ff) + SUM_W'(s3_pay_ff) + SUM_W'(s3_ploss_ff);
      s4_last_ff <= s3_last_ff;
      s4_eof_ff  <= s3_eof_ff;
   end

   // final sum, round half up to Q16.16 and clamp
   assign sum_total = s4_gain_ff - s4_drop_ff;
   assign res       = RES_W'((sum_total + SUM_W'(32768)) >>> 16);

   always_comb begin
      push_entry.conc_next    = res[OUT_W-1:0];
      push_entry.clamp_status = CLAMP_NONE;
      push_entry.end_of_row   = s4_last_ff;
      push_entry.end_of_frame = s4_eof_ff;
      priority if (res[RES_W-1]) begin
         push_entry.conc_next    = '0;
         push_entry.clamp_status = CLAMP_NEG;
      end else if (|res[RES_W-2:OUT_W]) begin
         push_entry.conc_next    = '0;
         push_entry.clamp_status = CLAMP_OVF;
      end
   end

   // result buffer
   assign rsp_pop = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (v4_ff) begin
         fifo_mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         if (v4_ff) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         fifo_count_ff <= fifo_count_ff + FCNT_W'(v4_ff) - FCNT_W'(rsp_pop);
      end
   end

   assign rsp_chan.valid        = (fifo_count_ff != '0);
   assign rsp_chan.conc_next    = fifo_mem[rd_ptr_ff].conc_next;
   assign rsp_chan.clamp_status = fifo_mem[rd_ptr_ff].clamp_status;
   assign rsp_chan.end_of_row   = fifo_mem[rd_ptr_ff].end_of_row;
   assign rsp_chan.end_of_frame = fifo_mem[rd_ptr_ff].end_of_frame;

`ifndef SYNTHESIS
   // buffer plus in-flight beats never exceed the buffer depth
   assert property (@(posedge clock) disable iff (reset)
      occupancy <= OCC_W'(RSP_FIFO_DEPTH))
      else $error("result buffer overcommitted");

   // a clamped result always carries zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.clamp_status != CLAMP_NONE) |-> rsp_chan.conc_next == '0)
      else $error("clamped result is not zero");

   // frame end only on a row end
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.end_of_frame |-> rsp_chan.end_of_row)
      else $error("end of frame without end of row");

   // a padding beat closing a row returns the block to loading
   assert property (@(posedge clock) disable iff (reset)
      req_fire && emit_ff && pad && row_last |=> !emit_ff && first_row_ff)
      else $error("frame end did not restart loading");
`endif

endmodule

// ===== tb/testbench.sv =====
// testbench for advection_diffusion_stencil_top: directed and random cell streams
// checked beat by beat against a built-in stencil predictor
// depends on adst_pkg and the channel interfaces of adst_if.sv

module testbench;
   import adst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_W        = GRID_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 600;
   localparam int PHASE_ITEMS   = 70;
   localparam int LONG_HOLD     = 300;
   localparam int LATENCY_SLACK = 20;
   localparam int END_WAIT      = 4000;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_REPORTS   = 40;

   localparam logic MODE_CELL = 1'b0;
   localparam logic MODE_PAD  = 1'b1;

   // register indexes that decode to nothing
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

   typedef struct packed {
      logic              mode;
      logic [CONC_W-1:0] conc;
   } cell_beat_t;

   typedef struct packed {
      logic [OUT_W-1:0] conc_next;
      clamp_type        clamp;
      logic             end_of_row;
      logic             end_of_frame;
   } result_t;

   bit clock = 1'b0;
   bit reset = 1'b1;

   adst_req_if req_chan();
   adst_rsp_if rsp_chan();
   adst_csr_if csr_chan();

   advection_diffusion_stencil_top #(.GRID_WIDTH(GRID_W)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stimulus and expectations
   cell_beat_t  cells_to_send[$];
   result_t     pending_conc_results[$];

   // idling and hold-off controls
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned rsp_hold_left = 0;

   // statistics
   int unsigned cycle_count      = 0;
   int unsigned mismatch_count   = 0;
   int unsigned cells_accepted   = 0;
   int unsigned results_checked  = 0;
   int unsigned neg_clamps       = 0;
   int unsigned ovf_clamps       = 0;
   int unsigned rows_ended       = 0;
   int unsigned frames_queued    = 0;
   int unsigned reg_writes       = 0;
   int unsigned queued_effective = 0;

   // predictor copy of the block's registers and state
   logic signed [COEF_W-1:0] k_diff_x = '0;
   logic signed [COEF_W-1:0] k_diff_y = '0;
   logic signed [COEF_W-1:0] k_adv_x  = '0;
   logic signed [COEF_W-1:0] k_adv_y  = '0;
   logic signed [COEF_W-1:0] k_loss   = '0;
   logic [COLS_W-1:0]        cols_cfg = COLS_RESET;
   logic [CONC_W-1:0]        center_row_copy [GRID_W];
   logic [CONC_W-1:0]        upper_row_copy  [GRID_W];
   logic [CONC_W-1:0]        left_copy = '0;
   int unsigned              col_idx   = 0;
   bit                       emitting  = 1'b0;
   bit                       top_row   = 1'b1;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                   results_checked, name, got, want));
   endtask

   // coefficient times stencil term, floored to 2^-32
   function automatic logic signed [95:0] scaled_product(input logic signed [31:0] k,
                                                         input logic signed [63:0] t);
      logic signed [95:0] p;
      p = k * t;
      return p >>> 12;
   endfunction

   task automatic apply_reg_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      case (idx)
         REG_DIFF_X:  k_diff_x = value;
         REG_DIFF_Y:  k_diff_y = value;
         REG_ADV_X:   k_adv_x  = value;
         REG_ADV_Y:   k_adv_y  = value;
         REG_LOSS:    k_loss   = value;
         REG_COLUMNS: cols_cfg = value[COLS_W-1:0];
         default: ;
      endcase
   endtask

   // one stencil step for an accepted cell beat
   task automatic compute_next_conc(input cell_beat_t beat);
      int unsigned        w, j;
      bit                 pad, last;
      logic [CONC_W-1:0]  below;
      logic signed [63:0] c, l, r, u, d, grad_x, grad_y;
      logic signed [95:0] acc, rounded;
      result_t            res;
      w = cols_cfg;
      if (w < 1) w = 1;
      if (w > GRID_W) w = GRID_W;
      j = col_idx;
      if (j >= w) j = w - 1;
      last  = (j + 1 >= w);
      pad   = (beat.mode == MODE_PAD);
      below = pad ? '0 : beat.conc;

      // first row only fills the center store, padding is dropped
      if (!emitting) begin
         if (pad) return;
         center_row_copy[j] = below;
         if (last) begin
            col_idx  = 0;
            emitting = 1'b1;
         end else begin
            col_idx = j + 1;
         end
         return;
      end

      // five-point window, zero outside the grid
      c = $signed(center_row_copy[j]);
      l = (j > 0) ? $signed(left_copy) : 64'sd0;
      r = (j + 1 < w) ? $signed(center_row_copy[j + 1]) : 64'sd0;
      u = top_row ? 64'sd0 : $signed(upper_row_copy[j]);
      d = $signed(below);

      // upwind differences follow the sign of the advection coefficients
      grad_x = (k_adv_x >= 0) ? c - l : r - c;
      grad_y = (k_adv_y >= 0) ? c - u : d - c;

      acc = c <<< 16;
      acc = acc + scaled_product(k_diff_x, r - 2 * c + l);
      acc = acc + scaled_product(k_diff_y, d - 2 * c + u);
      acc = acc - scaled_product(k_adv_x, grad_x);
      acc = acc - scaled_product(k_adv_y, grad_y);
      acc = acc - scaled_product(k_loss, c);
      rounded = (acc + 96'sd32768) >>> 16;

      // clamp negative and overflowed values to zero
      if (rounded < 0) begin
         res.conc_next = '0;
         res.clamp     = CLAMP_NEG;
      end else if (rounded > 96'sh7FFF_FFFF) begin
         res.conc_next = '0;
         res.clamp     = CLAMP_OVF;
      end else begin
         res.conc_next = rounded[OUT_W-1:0];
         res.clamp     = CLAMP_NONE;
      end
      res.end_of_row   = last;
      res.end_of_frame = last && pad;
      pending_conc_results.push_back(res);

      // shift the row stores and the window
      upper_row_copy[j]  = center_row_copy[j];
      center_row_copy[j] = below;
      left_copy          = c[CONC_W-1:0];
      if (last) begin
         col_idx = 0;
         if (pad) begin
            emitting = 1'b0;
            top_row  = 1'b1;
         end else begin
            top_row = 1'b0;
         end
      end else begin
         col_idx = j + 1;
      end
   endtask

   // cell driver: beats move at edges with valid and ready high
   always @(posedge clock) begin : cell_driver
      cell_beat_t nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            compute_next_conc('{mode: req_chan.mode, conc: req_chan.conc_in});
            cells_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (cells_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = cells_to_send.pop_front();
               req_chan.valid   <= 1'b1;
               req_chan.mode    <= nxt.mode;
               req_chan.conc_in <= nxt.conc;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         rsp_hold_left <= LONG_HOLD;
         hold_served   <= hold_requests;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin : result_monitor
      result_t want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_conc_results.size() == 0) begin
               report_mismatch($sformatf("result beat %0h with nothing expected",
                                         rsp_chan.conc_next));
            end else begin
               want = pending_conc_results.pop_front();
               check_field("conc_next", rsp_chan.conc_next, want.conc_next);
               check_field("clamp_status", rsp_chan.clamp_status, want.clamp);
               check_field("end_of_row", rsp_chan.end_of_row, want.end_of_row);
               check_field("end_of_frame", rsp_chan.end_of_frame, want.end_of_frame);
               if (want.clamp == CLAMP_NEG) neg_clamps++;
               if (want.clamp == CLAMP_OVF) ovf_clamps++;
               if (want.end_of_row) rows_ended++;
            end
            results_checked++;
         end
         rsp_chan.ready <= (rsp_hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // timeout
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
   end

   task automatic set_idle_mode(input idle_mode_t m);
      case (m)
         IDLE_NONE:     begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 56; rsp_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  rsp_stall_pct = 56; end
         default:       begin send_idle_pct = 8;  rsp_stall_pct = 8;  end
      endcase
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      apply_reg_write(idx, value);
      csr_chan.valid <= 1'b0;
      reg_writes++;
   endtask

   task automatic configure(input logic [31:0] dx, dy, ax, ay, loss, cols);
      write_reg(REG_DIFF_X, dx);
      write_reg(REG_DIFF_Y, dy);
      write_reg(REG_ADV_X, ax);
      write_reg(REG_ADV_Y, ay);
      write_reg(REG_LOSS, loss);
      write_reg(REG_COLUMNS, cols);
      @(negedge clock);
   endtask

   task automatic push_cell(input logic mode, input logic [31:0] value, input bit counted);
      cells_to_send.push_back('{mode: mode, conc: value});
      if (counted) queued_effective++;
   endtask

   // wait until every beat is sent and every result is back
   task automatic wait_until_drained(input bit with_slack);
      do @(negedge clock);
      while (cells_to_send.size() != 0 || req_chan.valid || pending_conc_results.size() != 0);
      if (with_slack) repeat (LATENCY_SLACK) @(negedge clock);
   endtask

   function automatic logic [31:0] random_conc();
      case ($urandom_range(3))
         0, 1:    return $urandom;
         2:       return $urandom_range(32'h0010_0000);
         default: return 32'h0 - $urandom_range(32'h0001_0000);
      endcase
   endfunction

   function automatic logic [31:0] random_coef(input bit gentle);
      if (gentle) return $urandom_range(32'h0400_0000) - 32'h0200_0000;
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // a frame: grid rows, then a flush row; noise keeps the row boundaries
   task automatic queue_frame(input int unsigned width, input int unsigned rows,
                              input bit noisy);
      int unsigned r, col;
      bit pad;
      for (r = 0; r <= rows; r++) begin
         for (col = 0; col < width; col++) begin
            if (r == 0) begin
               // padding while loading is dropped by the block
               if (noisy && $urandom_range(7) == 0) push_cell(MODE_PAD, $urandom, 1'b0);
               pad = 1'b0;
            end else if (r < rows) begin
               pad = noisy && col + 1 < width && $urandom_range(7) == 0;
            end else begin
               pad = !(noisy && col + 1 < width && $urandom_range(3) == 0);
            end
            push_cell(pad ? MODE_PAD : MODE_CELL, random_conc(), 1'b1);
         end
      end
      frames_queued++;
   endtask

   initial begin : stimulus
      int unsigned phase, width, rand_target, phase_end;
      logic [31:0] cols_value;
      bit gentle;
      req_chan.valid   = 1'b0;
      req_chan.mode    = MODE_CELL;
      req_chan.conc_in = '0;
      rsp_chan.ready   = 1'b0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = REG_DIFF_X;
      csr_chan.data    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      set_idle_mode(IDLE_NONE);

      // single column (count of zero), growth and clamping at the extremes
      configure(32'h0, 32'h0800_0000, 32'h0, 32'h0, 32'hF000_0000, 32'd0);
      push_cell(MODE_PAD, 32'hDEAD_BEEF, 1'b0);
      push_cell(MODE_CELL, 32'h7FFF_FFFF, 1'b1);
      push_cell(MODE_CELL, 32'h7FFF_FFFF, 1'b1);
      push_cell(MODE_CELL, 32'h8000_0000, 1'b1);
      push_cell(MODE_CELL, 32'h0001_0000, 1'b1);
      push_cell(MODE_PAD, 32'h0000_0000, 1'b1);
      frames_queued++;
      wait_until_drained(1'b1);

      // three columns, negative advection, padding mid-row and cells in the flush row
      configure(32'h7FFF_FFFF, 32'h0100_0000, 32'h8000_0000, 32'hFC00_0000,
                32'h0001_0000, 32'd3);
      push_cell(MODE_CELL, 32'h0000_0000, 1'b1);
      push_cell(MODE_CELL, 32'hFFFF_FFFF, 1'b1);
      push_cell(MODE_CELL, 32'h0001_8000, 1'b1);
      push_cell(MODE_PAD, 32'hFFFF_FFFF, 1'b1);
      push_cell(MODE_CELL, 32'h0002_0000, 1'b1);
      push_cell(MODE_CELL, 32'h0000_8000, 1'b1);
      push_cell(MODE_PAD, 32'h1234_5678, 1'b1);
      push_cell(MODE_CELL, 32'h0003_0000, 1'b1);
      push_cell(MODE_PAD, 32'h0, 1'b1);
      frames_queued++;
      wait_until_drained(1'b1);

      // two columns, positive advection, extreme negative loss; spare indexes decode to nothing
      configure(32'h0200_0000, 32'h0200_0000, 32'h0100_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'd2);
      write_reg(REG_SPARE_LO, $urandom);
      write_reg(REG_SPARE_HI, $urandom);
      @(negedge clock);
      push_cell(MODE_CELL, 32'h0010_0000, 1'b1);
      push_cell(MODE_CELL, 32'h0020_0000, 1'b1);
      push_cell(MODE_CELL, 32'h0030_0000, 1'b1);
      push_cell(MODE_CELL, 32'h0040_0000, 1'b1);
      push_cell(MODE_PAD, 32'h0, 1'b1);
      push_cell(MODE_PAD, 32'h0, 1'b1);
      frames_queued++;
      wait_until_drained(1'b1);

      // random phases, each with its own settings and idling
      rand_target = queued_effective + RANDOM_ITEMS;
      phase = 0;
      while (queued_effective < rand_target) begin
         set_idle_mode(idle_mode_t'(phase % 4));
         gentle = $urandom_range(9) < 7;
         width  = ($urandom_range(5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         cols_value = (width == 1 && $urandom_range(1) == 1) ? 32'd0 : width;
         if ($urandom_range(1) == 1) cols_value[31:COLS_W] = $urandom;
         configure(random_coef(gentle), random_coef(gentle), random_coef(gentle),
                   random_coef(gentle), random_coef(gentle), cols_value);
         // receiver holds off while the sender keeps offering beats
         if (phase == 0) hold_requests++;
         phase_end = queued_effective + PHASE_ITEMS;
         while (queued_effective < phase_end) begin
            queue_frame(width, $urandom_range(1, 4), $urandom_range(3) != 0);
            // sender pauses until every result is back
            if (phase == 3) wait_until_drained(1'b0);
         end
         wait_until_drained(1'b1);
         phase++;
      end

      // widest grid, column count above the maximum
      set_idle_mode(IDLE_BOTH);
      configure(random_coef(1'b1), random_coef(1'b1), random_coef(1'b1),
                random_coef(1'b1), random_coef(1'b1), 32'd2047);
      queue_frame(GRID_W, 1, 1'b1);
      wait_until_drained(1'b0);

      // drain and settle
      for (int k = 0; k < END_WAIT && pending_conc_results.size() != 0; k++)
         @(negedge clock);
      repeat (LATENCY_SLACK) @(negedge clock);
      if (pending_conc_results.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_conc_results.size()));

      $display("run covered %0d cell beats in %0d frames, %0d results, %0d register writes",
               cells_accepted, frames_queued, results_checked, reg_writes);
      $display("rows ended %0d, negative clamps %0d, overflow clamps %0d, mismatches %0d",
               rows_ended, neg_clamps, ovf_clamps, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
